>>> sv/tsat_pkg.sv
// ----------------------------------------------------------------------------
// tsat_pkg
// Types and constants shared by the three-sigma activity threshold unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsat_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned SumW    = 31;
  localparam int unsigned SqSumW  = 55;
  localparam int unsigned CountW  = 7;
  localparam int unsigned ThrW    = 27;
  localparam int unsigned VarW    = 48;
  localparam int unsigned NumW    = 60;
  localparam int unsigned QuoW    = 64;
  localparam int unsigned RemW    = 50;
  localparam int unsigned DenW    = 49;
  localparam int unsigned GW      = 16;
  localparam int unsigned SdW     = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_PREP,
    ST_MEAN,
    ST_VAR,
    ST_SQRT,
    ST_GDIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> sv/three_sigma_activity_threshold_unit.sv
// ----------------------------------------------------------------------------
// three_sigma_activity_threshold_unit
// Mean, sample variance and three-sigma threshold over one gene's samples.
// ----------------------------------------------------------------------------
// Each sample request is accepted in the idle state and then added, with its
// square, into the accumulators in the accumulate state; no new sample is
// taken meanwhile. After the sample flagged by tlast the result goes through
// one shared restoring divider and a square root unit, both one bit per cycle,
// in the steps setup, mean, variance, root, gain, product, sum and hand-off;
// a gene with too few or too many samples goes straight to hand-off, and the
// hand-off stalls while an older result still waits. A finished result waits
// in the output register while samples of the next gene come in.
`default_nettype none

module three_sigma_activity_threshold_unit #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,   // [23:0] sample
  input  wire logic         s_axis_tlast,   // last_sample
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // [26:0] threshold, [50:27] mean_value,
                                            // [98:51] variance_value, zero pad
  output logic              m_axis_tuser    // bad_count
);

  tsat_pkg::state_e state_q, state_d;

  logic signed [tsat_pkg::SampleW-1:0] smp_q;
  logic                                last_q;
  logic signed [tsat_pkg::SumW-1:0]    sum_q;
  logic [tsat_pkg::SqSumW-1:0]         sq_q;
  logic [tsat_pkg::CountW-1:0]         cnt_q;
  logic                                ovf_q;
  logic                                bad_q;

  logic [61:0]                 nsq_q;
  logic [61:0]                 magsq_q;
  logic [13:0]                 nn_q;
  logic [tsat_pkg::RemW-1:0]   div_rem_q;
  logic [tsat_pkg::QuoW-1:0]   div_quo_q;
  logic [tsat_pkg::DenW-1:0]   div_den_q;
  logic [6:0]                  step_q;
  logic signed [tsat_pkg::SampleW-1:0] mean_q;
  logic [tsat_pkg::VarW-1:0]   var_q;
  logic [tsat_pkg::VarW-1:0]   sq_x_q;
  logic [tsat_pkg::VarW-1:0]   sq_root_q;
  logic [tsat_pkg::VarW-1:0]   sq_bit_q;
  logic [tsat_pkg::SdW-1:0]    sd_q;
  logic [39:0]                 prod_q;
  logic signed [tsat_pkg::ThrW-1:0] thr_q;

  logic                        out_vld_q;
  logic [tsat_pkg::ThrW-1:0]   o_thr_q;
  logic [tsat_pkg::SampleW-1:0] o_mean_q;
  logic [tsat_pkg::VarW-1:0]   o_var_q;
  logic                        o_bad_q;

  logic                        accept;
  logic                        at_max;
  logic                        bad_now;
  logic [47:0]                 smp_sq;
  logic [tsat_pkg::SumW-1:0]   mag;
  logic [tsat_pkg::RemW-1:0]   rem_sh;
  logic                        div_ge;
  logic [tsat_pkg::RemW-1:0]   rem_nx;
  logic [tsat_pkg::QuoW-1:0]   quo_nx;
  logic [tsat_pkg::VarW:0]     sq_trial;
  logic                        sq_ge;
  logic [tsat_pkg::NumW-1:0]   num;
  logic [tsat_pkg::VarW-1:0]   var_sat;
  logic                        out_free;
  logic [41:0]                 prod3;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign at_max   = (cnt_q == tsat_pkg::CountW'(MAX_SAMPLES));
  assign bad_now  = ovf_q || at_max || (cnt_q < tsat_pkg::CountW'(1));
  assign smp_sq   = 48'($signed(smp_q) * $signed(smp_q));
  assign mag      = sum_q[tsat_pkg::SumW-1] ? tsat_pkg::SumW'(-sum_q) : sum_q;
  assign rem_sh   = {div_rem_q[tsat_pkg::RemW-2:0], div_quo_q[tsat_pkg::QuoW-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den_q};
  assign rem_nx   = div_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
  assign quo_nx   = {div_quo_q[tsat_pkg::QuoW-2:0], div_ge};
  assign sq_trial = {1'b0, sq_root_q} + {1'b0, sq_bit_q};
  assign sq_ge    = {1'b0, sq_x_q} >= sq_trial;
  assign num      = tsat_pkg::NumW'(nsq_q - magsq_q);
  assign var_sat  = (quo_nx[tsat_pkg::NumW-1:tsat_pkg::VarW] != '0) ? '1
                                                                    : quo_nx[tsat_pkg::VarW-1:0];
  assign out_free = !out_vld_q || m_axis_tready;
  assign prod3    = {2'b0, prod_q} + {1'b0, prod_q, 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsat_pkg::ST_IDLE: if (accept) state_d = tsat_pkg::ST_ACC;
      tsat_pkg::ST_ACC: begin
        if (!last_q) state_d = tsat_pkg::ST_IDLE;
        else if (bad_now) state_d = tsat_pkg::ST_DONE;
        else state_d = tsat_pkg::ST_PREP;
      end
      tsat_pkg::ST_PREP: state_d = tsat_pkg::ST_MEAN;
      tsat_pkg::ST_MEAN: if (step_q == 7'd1) state_d = tsat_pkg::ST_VAR;
      tsat_pkg::ST_VAR:  if (step_q == 7'd1) state_d = tsat_pkg::ST_SQRT;
      tsat_pkg::ST_SQRT: if (step_q == 7'd1) state_d = tsat_pkg::ST_GDIV;
      tsat_pkg::ST_GDIV: if (step_q == 7'd1) state_d = tsat_pkg::ST_MUL;
      tsat_pkg::ST_MUL:  state_d = tsat_pkg::ST_SUM;
      tsat_pkg::ST_SUM:  state_d = tsat_pkg::ST_DONE;
      tsat_pkg::ST_DONE: if (out_free) state_d = tsat_pkg::ST_IDLE;
      default: state_d = tsat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    case (state_q)
      tsat_pkg::ST_IDLE: s_axis_tready = 1'b1;
      default:           s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsat_pkg::ST_IDLE;
      sum_q     <= '0;
      sq_q      <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      bad_q     <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tsat_pkg::ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        tsat_pkg::ST_ACC: begin
          if (at_max) begin
            ovf_q <= 1'b1;
          end else begin
            sum_q <= sum_q + tsat_pkg::SumW'(smp_q);
            sq_q  <= sq_q + tsat_pkg::SqSumW'(smp_sq);
            cnt_q <= cnt_q + 1'b1;
          end
          bad_q <= bad_now;
        end
        tsat_pkg::ST_PREP: step_q <= 7'd31;
        tsat_pkg::ST_MEAN: step_q <= (step_q == 7'd1) ? 7'd60 : step_q - 1'b1;
        tsat_pkg::ST_VAR:  step_q <= (step_q == 7'd1) ? 7'd24 : step_q - 1'b1;
        tsat_pkg::ST_SQRT: step_q <= (step_q == 7'd1) ? 7'd16 : step_q - 1'b1;
        tsat_pkg::ST_GDIV: step_q <= step_q - 1'b1;
        tsat_pkg::ST_DONE: begin
          if (out_free) begin
            sum_q     <= '0;
            sq_q      <= '0;
            cnt_q     <= '0;
            ovf_q     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    case (state_q)
      tsat_pkg::ST_PREP: begin
        nsq_q     <= 62'(sq_q * cnt_q);
        magsq_q   <= 62'(mag * mag);
        nn_q      <= 14'(cnt_q * (cnt_q - 1'b1));
        div_rem_q <= '0;
        div_quo_q <= {mag, 33'b0};
        div_den_q <= tsat_pkg::DenW'(cnt_q);
      end
      tsat_pkg::ST_MEAN: begin
        div_rem_q <= rem_nx;
        div_quo_q <= quo_nx;
        if (step_q == 7'd1) begin
          mean_q    <= sum_q[tsat_pkg::SumW-1] ? tsat_pkg::SampleW'(-quo_nx[30:0])
                                               : tsat_pkg::SampleW'(quo_nx[30:0]);
          div_rem_q <= '0;
          div_quo_q <= {num, 4'b0};
          div_den_q <= tsat_pkg::DenW'(nn_q);
        end
      end
      tsat_pkg::ST_VAR: begin
        div_rem_q <= rem_nx;
        div_quo_q <= quo_nx;
        if (step_q == 7'd1) begin
          var_q     <= var_sat;
          sq_x_q    <= var_sat;
          sq_root_q <= '0;
          sq_bit_q  <= 48'h4000_0000_0000;
        end
      end
      tsat_pkg::ST_SQRT: begin
        if (sq_ge) begin
          sq_x_q    <= tsat_pkg::VarW'({1'b0, sq_x_q} - sq_trial);
          sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
        end else begin
          sq_root_q <= sq_root_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        if (step_q == 7'd1) begin
          sd_q      <= sq_ge ? tsat_pkg::SdW'((sq_root_q >> 1) + sq_bit_q)
                             : tsat_pkg::SdW'(sq_root_q >> 1);
          div_rem_q <= tsat_pkg::RemW'(var_q);
          div_quo_q <= '0;
          div_den_q <= {1'b0, var_q} + (49'd1 << 32);
        end
      end
      tsat_pkg::ST_GDIV: begin
        div_rem_q <= rem_nx;
        div_quo_q <= quo_nx;
      end
      tsat_pkg::ST_MUL: prod_q <= sd_q * div_quo_q[tsat_pkg::GW-1:0];
      tsat_pkg::ST_SUM: thr_q <= tsat_pkg::ThrW'(mean_q) + tsat_pkg::ThrW'(prod3[41:16]);
      tsat_pkg::ST_DONE: begin
        if (out_free) begin
          o_bad_q  <= bad_q;
          o_thr_q  <= bad_q ? '0 : thr_q;
          o_mean_q <= bad_q ? '0 : mean_q;
          o_var_q  <= bad_q ? '0 : var_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, o_var_q, o_mean_q, o_thr_q};
  assign m_axis_tuser  = o_bad_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == tsat_pkg::ST_IDLE))
    else $error("ready outside idle");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tsat_pkg::CountW'(MAX_SAMPLES))
    else $error("sample count beyond maximum");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("bad result carries data");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsat_pkg::ST_DONE && out_free) |=> (cnt_q == '0 && !ovf_q))
    else $error("accumulators not cleared");

endmodule

`default_nettype wire

>>> bench/tsat_checker.sv
// ----------------------------------------------------------------------------
// tsat_checker
// Watches both streams of the threshold unit, computes the expected gene
// statistics from the accepted samples and compares every result request.
// ----------------------------------------------------------------------------
`default_nettype none

module tsat_checker #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,
  input  wire logic         s_axis_tlast,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [103:0] m_axis_tdata,
  input  wire logic         m_axis_tuser,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [26:0] threshold;
    logic [23:0] mean_value;
    logic [47:0] variance_value;
    logic        bad_count;
  } gene_stat_t;

  gene_stat_t      gene_stats_q[$];
  longint          acc_sum;
  longint unsigned acc_sq;
  int unsigned     acc_n;
  bit              acc_ovf;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic gene_stat_t gene_stat(longint sum, longint unsigned sq,
                                           int unsigned n, bit ovf);
    gene_stat_t      r;
    longint          mean, t;
    longint unsigned mag, num, v, sd, g, term;
    r = '0;
    if (ovf || n < 2) begin
      r.bad_count = 1'b1;
      return r;
    end
    mean = sum / longint'(n);
    mag = (sum < 0) ? -sum : sum;
    num = longint'(n) * sq - mag * mag;
    v = num / (longint'(n) * (n - 1));
    if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
    sd = int_sqrt(v);
    g = (v << 16) / (v + (64'd1 << 32));
    term = (3 * sd * g) >> 16;
    t = mean + longint'(term);
    r.threshold = t[26:0];
    r.mean_value = mean[23:0];
    r.variance_value = v[47:0];
    return r;
  endfunction

  assign pending_o = gene_stats_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint     s;
    gene_stat_t got, want;
    if (!rst_ni) begin
      acc_sum = 0;
      acc_sq = 0;
      acc_n = 0;
      acc_ovf = 0;
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s = longint'($signed(s_axis_tdata));
        if (acc_n < MAX_SAMPLES) begin
          acc_sum += s;
          acc_sq += longint'(s * s);
          acc_n++;
        end else begin
          acc_ovf = 1;
        end
        if (s_axis_tlast) begin
          gene_stats_q.push_back(gene_stat(acc_sum, acc_sq, acc_n, acc_ovf));
          acc_sum = 0;
          acc_sq = 0;
          acc_n = 0;
          acc_ovf = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.threshold = m_axis_tdata[26:0];
        got.mean_value = m_axis_tdata[50:27];
        got.variance_value = m_axis_tdata[98:51];
        got.bad_count = m_axis_tuser;
        if (gene_stats_q.size() == 0) begin
          $error("unexpected result request");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = gene_stats_q.pop_front();
          if (got != want) begin
            if (got.threshold != want.threshold)
              $error("threshold expected %0h actual %0h", want.threshold, got.threshold);
            if (got.mean_value != want.mean_value)
              $error("mean_value expected %0h actual %0h", want.mean_value, got.mean_value);
            if (got.variance_value != want.variance_value)
              $error("variance_value expected %0h actual %0h",
                     want.variance_value, got.variance_value);
            if (got.bad_count != want.bad_count)
              $error("bad_count expected %0h actual %0h", want.bad_count, got.bad_count);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives genes of random and corner samples into the threshold unit with
// random gaps on both streams; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSamples = 64;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [23:0]   s_axis_tdata = '0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;
  logic          m_axis_tuser;
  int            fail_count;
  int            pending;
  bit            calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  three_sigma_activity_threshold_unit #(.MAX_SAMPLES(MaxSamples)) dut (.*);

  tsat_checker #(.MAX_SAMPLES(MaxSamples)) checker_i (
    .*, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    int n;
    bit rdy;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 16);
      rdy = ($urandom_range(0, 2) != 0);
      repeat (n) begin
        @(posedge clk_i);
        m_axis_tready <= calm ? 1'b1 : rdy;
      end
    end
  end

  task automatic send_sample(logic [23:0] d, logic l);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_sample(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(0, 1 << 18)) - 24'd65536;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_gene(int n, int mode);
    for (int i = 0; i < n; i++)
      send_sample(pick_sample(mode == 4 ? $urandom_range(0, 3) : mode), i == n - 1);
  endtask

  initial begin
    int sent, n, wait_cnt;
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gene(1, 3);
    send_gene(2, 0);
    send_gene(2, 1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h000000, 1'b0);
    send_sample(24'h000000, 1'b1);
    send_gene(3, 2);
    send_gene(4, 3);
    send_gene(MaxSamples + 2, 3);
    sent = 0;
    while (sent < 740) begin
      if (sent > 600) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: n = 1;
        1: n = MaxSamples + $urandom_range(0, 3);
        default: n = $urandom_range(2, 12);
      endcase
      send_gene(n, $urandom_range(0, 9) < 7 ? $urandom_range(2, 4) : $urandom_range(0, 1));
      sent += n;
      if (sent > 350 && !paused) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
